### sv/edfq_pkg.sv
// ----------------------------------------------------------------------------
// edfq_pkg: shared types and constants of the EDF run queue
// Sizes, request and status codes, and the entry and command structs that
// pass between the top level and the cells of the sorted chain.
// ----------------------------------------------------------------------------
package edfq_pkg;

  localparam int DEPTH  = 16;
  localparam int ID_W   = 8;
  localparam int DL_W   = 64;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CTR_W  = 32;
  localparam int MODE_W = 3;
  localparam int STAT_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_ENQ     = 3'd0,
    MODE_DEQ     = 3'd1,
    MODE_PEEK    = 3'd2,
    MODE_PREEMPT = 3'd3,
    MODE_TICK    = 3'd4
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_UNKNOWN = 2'd2,
    STAT_DUP     = 2'd3
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic [DL_W-1:0] dl;
  } entry_t;

  typedef struct packed {
    logic enq;
    logic deq;
  } cell_cmd_t;

endpackage

### sv/edfq_req_if.sv
// ----------------------------------------------------------------------------
// edfq_req_if: request channel of the EDF run queue
// Valid/ready handshake carrying one request per transaction.
// ----------------------------------------------------------------------------
interface edfq_req_if;
  logic                             valid;
  logic                             ready;
  logic [edfq_pkg::MODE_W-1:0]      mode;
  logic [edfq_pkg::ID_W-1:0]        entity_id;
  logic [edfq_pkg::DL_W-1:0]        deadline;
  logic                             running_valid;
  logic [edfq_pkg::DL_W-1:0]        now;

  modport source (output valid, mode, entity_id, deadline, running_valid, now,
                  input ready);
  modport sink   (input valid, mode, entity_id, deadline, running_valid, now,
                  output ready);
endinterface

### sv/edfq_rsp_if.sv
// ----------------------------------------------------------------------------
// edfq_rsp_if: response channel of the EDF run queue
// Valid/ready handshake carrying one result per transaction.
// ----------------------------------------------------------------------------
interface edfq_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [edfq_pkg::ID_W-1:0]        head_id;
  logic [edfq_pkg::DL_W-1:0]        head_deadline;
  logic                             queue_empty;
  logic [edfq_pkg::CNT_W-1:0]       entry_count;
  logic [edfq_pkg::DL_W-1:0]        earliest;
  logic                             preempt;
  logic                             deadline_missed;
  logic [edfq_pkg::CTR_W-1:0]       preempt_total;
  logic [edfq_pkg::STAT_W-1:0]      status;

  modport source (output valid, head_id, head_deadline, queue_empty, entry_count,
                  earliest, preempt, deadline_missed, preempt_total, status,
                  input ready);
  modport sink   (input valid, head_id, head_deadline, queue_empty, entry_count,
                  earliest, preempt, deadline_missed, preempt_total, status,
                  output ready);
endinterface

### sv/edfq_cell.sv
// ----------------------------------------------------------------------------
// edfq_cell: one slot of the sorted queue
// Holds one entry, compares it against the request key, and on a command
// keeps its entry, takes the new one, or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module edfq_cell (
  input  logic                clk,
  input  edfq_pkg::entry_t    key,
  input  edfq_pkg::cell_cmd_t cmd,
  input  logic                valid,
  input  logic                left_le,
  input  edfq_pkg::entry_t    left,
  input  edfq_pkg::entry_t    right,
  input  logic                found_in,
  output logic                found_out,
  output logic                le_out,
  output edfq_pkg::entry_t    entry,
  output edfq_pkg::entry_t    entry_next
);

  logic hit;

  assign hit       = valid && (entry.id == key.id);
  assign found_out = found_in | hit;
  // Valid entries form a sorted prefix, so le_out is high on a prefix too.
  assign le_out    = valid && (entry.dl <= key.dl);

  always_comb begin
    entry_next = entry;
    if (cmd.enq) begin
      if (!le_out) begin
        if (left_le) begin
          entry_next = key;
        end else begin
          entry_next = left;
        end
      end
    end else if (cmd.deq) begin
      if (found_out) begin
        entry_next = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

### sv/edf_deadline_run_queue.sv
// ----------------------------------------------------------------------------
// edf_deadline_run_queue: earliest-deadline-first run queue
// Sorted chain of cells with a registered response stage.
// ----------------------------------------------------------------------------
// The queue accepts one request per clock cycle and returns its result in the
// cycle after acceptance; a new request is taken while the previous result
// waits, as long as the response register is free or being drained. All
// sixteen cells compare their entries with the request in parallel: an
// enqueue shifts the later entries one cell to the right, and a dequeue
// shifts the entries behind the matching cell one cell to the left, where the
// match position ripples along the chain within the same cycle. No clearing
// pass is needed after reset.
module edf_deadline_run_queue (
  input  logic       clk,
  input  logic       rst,
  edfq_req_if.sink   req,
  edfq_rsp_if.source rsp
);

  localparam int DEPTH = edfq_pkg::DEPTH;

  edfq_pkg::entry_t    ent      [DEPTH];
  edfq_pkg::entry_t    ent_next [DEPTH];
  edfq_pkg::entry_t    key;
  edfq_pkg::cell_cmd_t cmd;
  logic [DEPTH:0]      found;
  logic [DEPTH-1:0]    le;
  logic [DEPTH-1:0]    vld;

  logic [edfq_pkg::CNT_W-1:0]  occupancy;
  logic [edfq_pkg::CNT_W-1:0]  occupancy_next;
  logic [edfq_pkg::DL_W-1:0]   earliest;
  logic [edfq_pkg::DL_W-1:0]   earliest_next;
  logic [edfq_pkg::CTR_W-1:0]  preempt_counter;
  logic [edfq_pkg::CTR_W-1:0]  preempt_counter_next;
  logic                        out_valid;
  logic                        accept;
  logic                        is_enq;
  logic                        is_deq;
  logic                        is_chk;
  logic                        is_tick;
  logic                        full;
  logic                        pre;
  logic                        miss;
  edfq_pkg::status_t           status_next;

  logic [edfq_pkg::ID_W-1:0]   head_id;
  logic [edfq_pkg::DL_W-1:0]   head_deadline;
  logic                        queue_empty;
  logic                        preempt;
  logic                        deadline_missed;
  edfq_pkg::status_t           status;

  assign key.id = req.entity_id;
  assign key.dl = req.deadline;
  assign found[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    edfq_pkg::entry_t left_ent;
    edfq_pkg::entry_t right_ent;
    logic             left_le;

    assign vld[i] = occupancy > edfq_pkg::CNT_W'(i);

    if (i == 0) begin : g_first
      assign left_le  = 1'b1;
      assign left_ent = ent[i];
    end else begin : g_mid
      assign left_le  = le[i-1];
      assign left_ent = ent[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_ent = ent[i];
    end else begin : g_inner
      assign right_ent = ent[i+1];
    end

    edfq_cell u_cell (
      .clk       (clk),
      .key       (key),
      .cmd       (cmd),
      .valid     (vld[i]),
      .left_le   (left_le),
      .left      (left_ent),
      .right     (right_ent),
      .found_in  (found[i]),
      .found_out (found[i+1]),
      .le_out    (le[i]),
      .entry     (ent[i]),
      .entry_next(ent_next[i])
    );
  end

  assign accept  = req.valid && req.ready;
  assign is_enq  = req.mode == edfq_pkg::MODE_ENQ;
  assign is_deq  = req.mode == edfq_pkg::MODE_DEQ;
  assign is_chk  = req.mode == edfq_pkg::MODE_PREEMPT;
  assign is_tick = req.mode == edfq_pkg::MODE_TICK;
  assign full    = occupancy == edfq_pkg::CNT_W'(DEPTH);

  assign cmd.enq = accept && is_enq && !found[DEPTH] && !full;
  assign cmd.deq = accept && is_deq && found[DEPTH];

  // The preemption check looks at the queue before the request; neither
  // check nor tick changes the entries.
  always_comb begin
    pre  = 1'b0;
    miss = 1'b0;
    if ((is_chk || is_tick) && req.running_valid && occupancy != '0) begin
      pre = (ent[0].id != req.entity_id) && (ent[0].dl < req.deadline);
    end
    if (is_tick && req.running_valid) begin
      miss = req.now > req.deadline;
    end
  end

  always_comb begin
    occupancy_next       = occupancy;
    earliest_next        = earliest;
    preempt_counter_next = preempt_counter;
    status_next          = edfq_pkg::STAT_OK;
    if (is_enq) begin
      if (found[DEPTH]) begin
        status_next = edfq_pkg::STAT_DUP;
      end else if (full) begin
        status_next = edfq_pkg::STAT_FULL;
      end else begin
        occupancy_next = occupancy + 1'b1;
        if (req.deadline < earliest) begin
          earliest_next = req.deadline;
        end
      end
    end else if (is_deq) begin
      if (!found[DEPTH]) begin
        status_next = edfq_pkg::STAT_UNKNOWN;
      end else begin
        occupancy_next = occupancy - 1'b1;
        earliest_next  = (occupancy_next != '0) ? ent_next[0].dl : '1;
      end
    end else if (is_tick && pre) begin
      preempt_counter_next = preempt_counter + 1'b1;
    end
  end

  assign req.ready = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy       <= '0;
      earliest        <= '1;
      preempt_counter <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (accept) begin
        occupancy       <= occupancy_next;
        earliest        <= earliest_next;
        preempt_counter <= preempt_counter_next;
        out_valid       <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      head_id         <= (occupancy_next != '0) ? ent_next[0].id : '0;
      head_deadline   <= (occupancy_next != '0) ? ent_next[0].dl : '1;
      queue_empty     <= occupancy_next == '0;
      preempt         <= pre;
      deadline_missed <= miss;
      status          <= status_next;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.head_id         = head_id;
  assign rsp.head_deadline   = head_deadline;
  assign rsp.queue_empty     = queue_empty;
  assign rsp.entry_count     = occupancy;
  assign rsp.earliest        = earliest;
  assign rsp.preempt         = preempt;
  assign rsp.deadline_missed = deadline_missed;
  assign rsp.preempt_total   = preempt_counter;
  assign rsp.status          = status;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occupancy <= edfq_pkg::CNT_W'(DEPTH))
    else $error("occupancy exceeds queue depth");

  a_enq_count: assert property (@(posedge clk) disable iff (rst)
    accept && is_enq && !found[DEPTH] && !full |=>
      occupancy == $past(occupancy) + 1'b1 && status == edfq_pkg::STAT_OK)
    else $error("successful enqueue did not grow the queue");

  a_counter_tick_only: assert property (@(posedge clk) disable iff (rst)
    accept && !is_tick |=> preempt_counter == $past(preempt_counter))
    else $error("preemption counter changed outside a tick");

  a_empty_earliest: assert property (@(posedge clk) disable iff (rst)
    occupancy == '0 |-> earliest == '1)
    else $error("earliest deadline not all ones on an empty queue");
`endif

endmodule

### sim/tb_edf_deadline_run_queue.sv
// ----------------------------------------------------------------------------
// tb_edf_deadline_run_queue: self-checking bench for the EDF run queue
// Drives enqueue, dequeue, peek, preempt and tick requests through the
// request channel, keeps a sorted shadow queue that predicts every result,
// and compares each response transaction field by field against it.
// ----------------------------------------------------------------------------
module tb_edf_deadline_run_queue;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 4;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS   = 476;
  localparam int ID_POOL        = 23;
  localparam int SPARE_MODES    = (1 << edfq_pkg::MODE_W) - 1 - edfq_pkg::MODE_TICK;
  localparam logic [edfq_pkg::DL_W-1:0] DL_NONE = '1;

  typedef struct packed {
    logic [edfq_pkg::MODE_W-1:0] mode;
    logic [edfq_pkg::ID_W-1:0]   entity_id;
    logic [edfq_pkg::DL_W-1:0]   deadline;
    logic                        running_valid;
    logic [edfq_pkg::DL_W-1:0]   now;
  } run_req_t;

  typedef struct packed {
    logic [edfq_pkg::ID_W-1:0]  head_id;
    logic [edfq_pkg::DL_W-1:0]  head_deadline;
    logic                       queue_empty;
    logic [edfq_pkg::CNT_W-1:0] entry_count;
    logic [edfq_pkg::DL_W-1:0]  earliest;
    logic                       preempt;
    logic                       deadline_missed;
    logic [edfq_pkg::CTR_W-1:0] preempt_total;
    edfq_pkg::status_t          status;
  } rq_view_t;

  typedef enum int {LOAD_FILL, LOAD_DRAIN, LOAD_MIXED} load_profile_t;

  logic clk = 1'b0;
  logic rst;

  edfq_req_if req_ch ();
  edfq_rsp_if rsp_ch ();

  edf_deadline_run_queue dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Shadow of the sorted queue and its registers.
  edfq_pkg::entry_t           shadow_q[$];
  logic [edfq_pkg::DL_W-1:0]  shadow_earliest = DL_NONE;
  logic [edfq_pkg::CTR_W-1:0] shadow_preempts = '0;

  rq_view_t views_due[$];

  int gap_pct = 24;
  int stall_pct = 53;
  int failures = 0;
  int requests_sent = 0;
  int results_checked = 0;
  int peak_depth = 0;
  int status_tally[4] = '{0, 0, 0, 0};
  int stalled_cycles = 0;

  function automatic logic [edfq_pkg::DL_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Applies one request to the shadow queue and returns the view it leaves.
  function automatic rq_view_t step_run_queue(input run_req_t r);
    rq_view_t view;
    int hit;
    int pos;
    logic due;
    view = '0;
    view.status = edfq_pkg::STAT_OK;
    hit = -1;
    foreach (shadow_q[i])
      if (hit < 0 && shadow_q[i].id == r.entity_id) hit = i;
    due = 1'b0;
    if (r.running_valid && shadow_q.size() != 0) begin
      due = shadow_q[0].id != r.entity_id && shadow_q[0].dl < r.deadline;
    end
    case (r.mode)
      edfq_pkg::MODE_ENQ: begin
        if (hit >= 0) begin
          view.status = edfq_pkg::STAT_DUP;
        end else if (shadow_q.size() >= edfq_pkg::DEPTH) begin
          view.status = edfq_pkg::STAT_FULL;
        end else begin
          // Ties go behind every entry with the same deadline.
          pos = 0;
          while (pos < shadow_q.size() && shadow_q[pos].dl <= r.deadline) pos++;
          shadow_q.insert(pos, '{id: r.entity_id, dl: r.deadline});
          if (r.deadline < shadow_earliest) shadow_earliest = r.deadline;
        end
      end
      edfq_pkg::MODE_DEQ: begin
        if (hit < 0) begin
          view.status = edfq_pkg::STAT_UNKNOWN;
        end else begin
          shadow_q.delete(hit);
          shadow_earliest = shadow_q.size() != 0 ? shadow_q[0].dl : DL_NONE;
        end
      end
      edfq_pkg::MODE_PREEMPT: begin
        view.preempt = due;
      end
      edfq_pkg::MODE_TICK: begin
        if (r.running_valid) begin
          view.deadline_missed = r.now > r.deadline;
          view.preempt = due;
          if (due) shadow_preempts = shadow_preempts + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (shadow_q.size() != 0) begin
      view.head_id = shadow_q[0].id;
      view.head_deadline = shadow_q[0].dl;
    end else begin
      view.head_deadline = DL_NONE;
    end
    view.queue_empty = shadow_q.size() == 0;
    view.entry_count = edfq_pkg::CNT_W'(shadow_q.size());
    view.earliest = shadow_earliest;
    view.preempt_total = shadow_preempts;
    status_tally[view.status]++;
    if (shadow_q.size() > peak_depth) peak_depth = shadow_q.size();
    return view;
  endfunction

  task automatic send_request(input run_req_t r);
    while ($urandom_range(99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.mode <= r.mode;
    req_ch.entity_id <= r.entity_id;
    req_ch.deadline <= r.deadline;
    req_ch.running_valid <= r.running_valid;
    req_ch.now <= r.now;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    views_due.push_back(step_run_queue(r));
    requests_sent++;
  endtask

  task automatic issue(input logic [edfq_pkg::MODE_W-1:0] mode,
                       input logic [edfq_pkg::ID_W-1:0] id,
                       input logic [edfq_pkg::DL_W-1:0] dl, input logic rv,
                       input logic [edfq_pkg::DL_W-1:0] t_now);
    run_req_t r;
    r = '{mode: mode, entity_id: id, deadline: dl, running_valid: rv, now: t_now};
    send_request(r);
  endtask

  // Holds the request channel quiet until every outstanding result is back.
  task automatic wait_for_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (views_due.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [edfq_pkg::DL_W-1:0] want,
                             input logic [edfq_pkg::DL_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      failures++;
    end
  endtask

  function automatic logic [edfq_pkg::DL_W-1:0] pick_deadline();
    int roll;
    edfq_pkg::entry_t e;
    roll = $urandom_range(99);
    if (roll < 35) return edfq_pkg::DL_W'($urandom_range(40));
    if (roll < 65 && shadow_q.size() != 0) begin
      e = shadow_q[$urandom_range(shadow_q.size() - 1)];
      return e.dl + $urandom_range(2) - 1;
    end
    if (roll < 85) return rand64();
    if (roll < 93) return '0;
    return DL_NONE;
  endfunction

  function automatic run_req_t draw_request(input load_profile_t prof);
    run_req_t r;
    int roll;
    int enq_w;
    int deq_w;
    r.mode = edfq_pkg::MODE_PEEK;
    r.entity_id = edfq_pkg::ID_W'($urandom_range(99) < 85 ? $urandom_range(ID_POOL)
                                                           : $urandom_range(255));
    r.deadline = rand64();
    r.running_valid = $urandom_range(99) < 85;
    r.now = rand64();
    case (prof)
      LOAD_FILL:  begin enq_w = 65; deq_w = 10; end
      LOAD_DRAIN: begin enq_w = 10; deq_w = 65; end
      default:    begin enq_w = 30; deq_w = 25; end
    endcase
    roll = $urandom_range(99);
    if (roll < enq_w) begin
      r.mode = edfq_pkg::MODE_ENQ;
      r.deadline = pick_deadline();
    end else if (roll < enq_w + deq_w) begin
      r.mode = edfq_pkg::MODE_DEQ;
      if (shadow_q.size() != 0 && $urandom_range(99) < 75)
        r.entity_id = shadow_q[$urandom_range(shadow_q.size() - 1)].id;
    end else if (roll < enq_w + deq_w + 2) begin
      r.mode = edfq_pkg::MODE_W'(edfq_pkg::MODE_TICK + $urandom_range(1, SPARE_MODES));
    end else if (roll < enq_w + deq_w + 5) begin
      r.mode = edfq_pkg::MODE_PEEK;
    end else begin
      r.mode = $urandom_range(1) ? edfq_pkg::MODE_PREEMPT : edfq_pkg::MODE_TICK;
      if (shadow_q.size() != 0 && $urandom_range(1)) r.entity_id = shadow_q[0].id;
      r.deadline = pick_deadline();
      case ($urandom_range(3))
        0: r.now = r.deadline - 1'b1;
        1: r.now = r.deadline;
        2: r.now = r.deadline + 1'b1;
        default: r.now = rand64();
      endcase
    end
    return r;
  endfunction

  // Response side: random backpressure and in-order comparison.
  always @(posedge clk) begin : check_results
    rq_view_t want;
    rsp_ch.ready <= $urandom_range(99) >= stall_pct;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (views_due.size() == 0) begin
        $error("response transaction with no request outstanding");
        failures++;
      end else begin
        want = views_due.pop_front();
        check_field("head_id", edfq_pkg::DL_W'(want.head_id),
                    edfq_pkg::DL_W'(rsp_ch.head_id));
        check_field("head_deadline", want.head_deadline, rsp_ch.head_deadline);
        check_field("queue_empty", edfq_pkg::DL_W'(want.queue_empty),
                    edfq_pkg::DL_W'(rsp_ch.queue_empty));
        check_field("entry_count", edfq_pkg::DL_W'(want.entry_count),
                    edfq_pkg::DL_W'(rsp_ch.entry_count));
        check_field("earliest", want.earliest, rsp_ch.earliest);
        check_field("preempt", edfq_pkg::DL_W'(want.preempt),
                    edfq_pkg::DL_W'(rsp_ch.preempt));
        check_field("deadline_missed", edfq_pkg::DL_W'(want.deadline_missed),
                    edfq_pkg::DL_W'(rsp_ch.deadline_missed));
        check_field("preempt_total", edfq_pkg::DL_W'(want.preempt_total),
                    edfq_pkg::DL_W'(rsp_ch.preempt_total));
        check_field("status", edfq_pkg::DL_W'(want.status),
                    edfq_pkg::DL_W'(rsp_ch.status));
        results_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        stalled_cycles <= 0;
      end else begin
        stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("edf_deadline_run_queue: mismatch");
        $finish;
      end
    end
  end

  task automatic test_empty_queue();
    issue(edfq_pkg::MODE_PEEK, '0, '0, 1'b0, '0);
    issue(edfq_pkg::MODE_DEQ, 8'd7, '0, 1'b0, '0);
    issue(edfq_pkg::MODE_TICK, '0, '0, 1'b0, DL_NONE);
    issue(edfq_pkg::MODE_TICK, 8'd3, 64'd10, 1'b1, 64'd11);
    issue(edfq_pkg::MODE_PREEMPT, 8'd3, DL_NONE, 1'b1, '0);
  endtask

  task automatic test_ordering_and_status();
    issue(edfq_pkg::MODE_ENQ, '1, DL_NONE, 1'b0, '0);
    issue(edfq_pkg::MODE_ENQ, '0, '0, 1'b0, '0);
    issue(edfq_pkg::MODE_ENQ, 8'd5, 64'd100, 1'b0, '0);
    // Equal deadline: the later arrival must sit behind id 5.
    issue(edfq_pkg::MODE_ENQ, 8'd6, 64'd100, 1'b1, DL_NONE);
    issue(edfq_pkg::MODE_ENQ, 8'd5, 64'd3, 1'b0, '0);
    issue(edfq_pkg::MODE_DEQ, 8'd6, '0, 1'b0, '0);
    issue(edfq_pkg::MODE_DEQ, '0, '0, 1'b0, '0);
    issue(edfq_pkg::MODE_DEQ, '0, '0, 1'b0, '0);
  endtask

  task automatic test_preempt_and_tick();
    issue(edfq_pkg::MODE_PREEMPT, 8'd9, 64'd101, 1'b1, '0);
    issue(edfq_pkg::MODE_PREEMPT, 8'd5, 64'd200, 1'b1, '0);
    issue(edfq_pkg::MODE_PREEMPT, 8'd9, 64'd100, 1'b1, '0);
    issue(edfq_pkg::MODE_PREEMPT, 8'd9, 64'd101, 1'b0, '0);
    issue(edfq_pkg::MODE_TICK, 8'd9, 64'd101, 1'b1, 64'd101);
    issue(edfq_pkg::MODE_TICK, 8'd9, '0, 1'b1, DL_NONE);
    issue(edfq_pkg::MODE_TICK, 8'd9, 64'd101, 1'b0, DL_NONE);
  endtask

  task automatic test_spare_modes();
    for (int m = 1; m <= SPARE_MODES; m++)
      issue(edfq_pkg::MODE_W'(edfq_pkg::MODE_TICK + m), 8'd5, rand64(), 1'b1, rand64());
  endtask

  task automatic test_random_traffic(input int gap, input int stall, input int n_items);
    int sent;
    int burst;
    load_profile_t prof;
    gap_pct = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(2))
        0: prof = LOAD_FILL;
        1: prof = LOAD_DRAIN;
        default: prof = LOAD_MIXED;
      endcase
      burst = $urandom_range(6, 40);
      for (int i = 0; i < burst && sent < n_items; i++) begin
        send_request(draw_request(prof));
        sent++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.mode <= edfq_pkg::MODE_PEEK;
    req_ch.entity_id <= '0;
    req_ch.deadline <= '0;
    req_ch.running_valid <= 1'b0;
    req_ch.now <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_empty_queue();
    test_ordering_and_status();
    test_preempt_and_tick();
    test_spare_modes();
    test_random_traffic(24, 53, RANDOM_ITEMS);
    test_random_traffic(53, 24, RANDOM_ITEMS);
    test_random_traffic(0, 0, RANDOM_ITEMS);

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d requests and %0d checked results; peak depth %0d of %0d.",
             requests_sent, results_checked, peak_depth, edfq_pkg::DEPTH);
    $display("Rejections: %0d full, %0d unknown id, %0d duplicate id; %0d preemptions.",
             status_tally[edfq_pkg::STAT_FULL], status_tally[edfq_pkg::STAT_UNKNOWN],
             status_tally[edfq_pkg::STAT_DUP], shadow_preempts);
    if (failures == 0) begin
      $display("edf_deadline_run_queue: match");
    end else begin
      $display("edf_deadline_run_queue: mismatch");
    end
    $finish;
  end

endmodule
